// ===== design/ple_pkg.sv =====
// Package for the positional list engine: sizes, action and status codes,
// and the storage request type shared by the sequencer and its storage.
// Depends on nothing.
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_DUMP   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== design/ple_if.sv =====
// Handshake channels of the positional list engine: request and response words.
// Depends on ple_pkg.
interface ple_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       action;
	logic [ple_pkg::CNT_W-1:0]        position;
	logic signed [ple_pkg::VAL_W-1:0] value;

	modport source (output valid, output action, output position, output value, input ready);
	modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface ple_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic [ple_pkg::CNT_W-1:0]        count;
	logic signed [ple_pkg::VAL_W-1:0] item;
	logic                             item_valid;
	logic                             last;

	modport source (output valid, output status, output count, output item,
		output item_valid, output last, input ready);
	modport sink   (input valid, input status, input count, input item,
		input item_valid, input last, output ready);
endinterface

// ===== design/ple_ram.sv =====
// Entry storage of the positional list engine: one write port, one read port
// with registered read data. Depends on ple_pkg.
module ple_ram (
	input  logic                         clk,
	input  ple_pkg::ram_req_t            req,
	output logic [ple_pkg::VAL_W-1:0]    rdata
);

	logic [ple_pkg::VAL_W-1:0] mem [ple_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

// ===== design/positional_list_engine.sv =====
// Positional list engine: an ordered list of signed 32-bit values with insert,
// delete and dump, stored in one memory and moved one entry at a time.
// After a word is accepted, ready stays low while entries are shifted on insert or
// delete or read out on a dump, and on every word until its response is loaded,
// plus any output stall; the memory's single read and write port sets each shift's pace.
// Reset clears the count and control state; entries are undefined until written.
module positional_list_engine (
	input  logic          clk,
	input  logic          arst_n,
	ple_req_if.sink       req,
	ple_rsp_if.source     rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_INS_STEP, S_INS_WR, S_DEL_STEP, S_DEL_WR, S_DUMP_RD, S_DUMP_OUT, S_RESP
	} state_t;

	state_t                          state_q;
	logic [ple_pkg::CNT_W-1:0]       idx_q;
	logic [ple_pkg::CNT_W-1:0]       pos_q;
	logic [ple_pkg::CNT_W-1:0]       count_q;
	logic [ple_pkg::VAL_W-1:0]       val_q;
	logic [1:0]                      resp_status_q;

	logic                            out_valid_q;
	logic [1:0]                      out_status_q;
	logic [ple_pkg::CNT_W-1:0]       out_count_q;
	logic [ple_pkg::VAL_W-1:0]       out_item_q;
	logic                            out_item_valid_q;
	logic                            out_last_q;

	ple_pkg::ram_req_t               ram_req;
	logic [ple_pkg::VAL_W-1:0]       ram_rdata;
	logic [ple_pkg::CNT_W-1:0]       idx_dec;
	logic [ple_pkg::CNT_W-1:0]       idx_inc;
	logic                            out_free;
	logic                            out_load;
	logic                            accept;

	assign idx_dec  = idx_q - ple_pkg::CNT_W'(1);
	assign idx_inc  = idx_q + ple_pkg::CNT_W'(1);
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = out_free && (state_q == S_DUMP_OUT || state_q == S_RESP);
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.count      = out_count_q;
	assign rsp.item       = out_item_q;
	assign rsp.item_valid = out_item_valid_q;
	assign rsp.last       = out_last_q;

	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = idx_q[ple_pkg::ADDR_W-1:0];
		ram_req.wdata = ram_rdata;
		ram_req.raddr = idx_q[ple_pkg::ADDR_W-1:0];
		case (state_q)
			S_INS_STEP: begin
				ram_req.raddr = idx_dec[ple_pkg::ADDR_W-1:0];
				if (idx_q == pos_q) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = val_q;
				end
			end
			S_INS_WR: ram_req.we = 1'b1;
			S_DEL_STEP: ram_req.raddr = idx_inc[ple_pkg::ADDR_W-1:0];
			S_DEL_WR: ram_req.we = 1'b1;
			default: ;
		endcase
	end

	ple_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			idx_q            <= '0;
			pos_q            <= '0;
			count_q          <= '0;
			val_q            <= '0;
			resp_status_q    <= ple_pkg::ST_OK;
			out_valid_q      <= 1'b0;
			out_status_q     <= ple_pkg::ST_OK;
			out_count_q      <= '0;
			out_item_q       <= '0;
			out_item_valid_q <= 1'b0;
			out_last_q       <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q <= req.position;
						val_q <= req.value;
						case (req.action)
							ple_pkg::ACT_INSERT: begin
								if (req.position > count_q) begin
									resp_status_q <= ple_pkg::ST_BAD;
									state_q       <= S_RESP;
								end else if (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY)) begin
									resp_status_q <= ple_pkg::ST_FULL;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= count_q;
									state_q <= S_INS_STEP;
								end
							end
							ple_pkg::ACT_DELETE: begin
								if (req.position >= count_q) begin
									resp_status_q <= ple_pkg::ST_BAD;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= req.position;
									state_q <= S_DEL_STEP;
								end
							end
							ple_pkg::ACT_DUMP: begin
								if (count_q == '0) begin
									resp_status_q <= ple_pkg::ST_OK;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= '0;
									state_q <= S_DUMP_RD;
								end
							end
							default: begin
								resp_status_q <= ple_pkg::ST_BAD;
								state_q       <= S_RESP;
							end
						endcase
					end
				end
				S_INS_STEP: begin
					if (idx_q == pos_q) begin
						count_q       <= count_q + ple_pkg::CNT_W'(1);
						resp_status_q <= ple_pkg::ST_OK;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_dec;
					state_q <= S_INS_STEP;
				end
				S_DEL_STEP: begin
					if (idx_inc == count_q) begin
						count_q       <= count_q - ple_pkg::CNT_W'(1);
						resp_status_q <= ple_pkg::ST_OK;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_inc;
					state_q <= S_DEL_STEP;
				end
				S_DUMP_RD: state_q <= S_DUMP_OUT;
				S_DUMP_OUT: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_status_q     <= ple_pkg::ST_OK;
						out_count_q      <= count_q;
						out_item_q       <= ram_rdata;
						out_item_valid_q <= 1'b1;
						out_last_q       <= (idx_inc == count_q);
						if (idx_inc == count_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_DUMP_RD;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_status_q     <= resp_status_q;
						out_count_q      <= count_q;
						out_item_q       <= '0;
						out_item_valid_q <= 1'b0;
						out_last_q       <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
